[sv/mesh_vertex_weld_assert.svh]
// Assertion macros shared by the vertex weld modules.
// Each expects clk in the scope where it is used; MVW_ASSERT also needs rst_n.
`ifndef MESH_VERTEX_WELD_ASSERT_SVH
`define MESH_VERTEX_WELD_ASSERT_SVH

`ifndef ASSERT_OFF
`define MVW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MVW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MVW_ASSERT(label, prop, msg)
`define MVW_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[sv/mvw_pkg.sv]
package mvw_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 32;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int TOL_W        = 31;
    localparam int SQ_W         = 2 * TOL_W;
    localparam int SUM_W        = 64;
    localparam int OUT_IDX_W    = 12;
    localparam int NUM_CORNERS  = 3;
    localparam int NUM_AXES     = 3;
    localparam int IN_DATA_W    = NUM_CORNERS * NUM_AXES * COORD_W;
    localparam int OUT_DATA_W   = 40;

    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   count_t;

    typedef struct packed {
        logic       start;
        logic       scan_step;
        logic       check;
        logic       wr_en;
        logic [1:0] wr_corner;
        logic       load_out;
    } mvw_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic pipe_busy;
        logic full;
    } mvw_status_t;

    typedef struct packed {
        logic                 table_full;
        logic                 new_c;
        logic                 new_b;
        logic                 new_a;
        logic [OUT_IDX_W-1:0] index_c;
        logic [OUT_IDX_W-1:0] index_b;
        logic [OUT_IDX_W-1:0] index_a;
    } mvw_result_t;

    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input addr_t a);
        logic [OUT_IDX_W+ADDR_W-1:0] ext;
        ext = {{OUT_IDX_W{1'b0}}, a};
        return ext[OUT_IDX_W-1:0];
    endfunction

endpackage

[sv/mesh_vertex_weld.sv]
// Vertex welding for a stream of triangles.
// Input channel s_axis: one item is one triangle, three corners of signed Q16.16
// coordinates packed in s_axis_tdata. Output channel m_axis: one item per triangle
// with the table index and a new flag for each corner, and the table full flag on
// m_axis_tuser. cfg_we and cfg_wdata write the weld tolerance; the user must write it
// only while the block is idle, which the block does not enforce. Each corner is welded
// to the lowest-numbered stored vertex closer than the tolerance; unmatched corners are
// appended to the table in corner order. A triangle is taken only when the controller
// is idle. The block reads the vertex table through one read port, one stored vertex a
// cycle, and compares it with all three corners at once. After a triangle is accepted,
// the block scans the n vertices stored before it (at most 4096), lets the compares
// drain, checks that the table has room, writes the unmatched corners and then loads
// the result into the output register once it is free; only then is the next triangle
// accepted. A full table skips the writes. Reset empties the table and clears the
// tolerance to zero, so that nothing welds. A finished result waits in the output
// register; while the receiver stalls the next triangle is still taken and searched,
// and its result waits until the register is free.
`include "mesh_vertex_weld_assert.svh"

module mesh_vertex_weld
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mvw_pkg::TOL_W-1:0]          cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz, 32 bits each from the lowest bit up.
    input  logic [mvw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // index_a, index_b, index_c (12 bits each), new_a, new_b, new_c, one zero bit.
    output logic [mvw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // table_full.
    output logic                               m_axis_tuser
);
    import mvw_pkg::*;

    mvw_cmd_t    cmd;
    mvw_status_t st;
    mvw_result_t result;
    mvw_result_t out_reg;
    logic        out_valid_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    mvw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .st       (st),
        .cmd      (cmd)
    );

    mvw_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .st        (st),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.new_c, out_reg.new_b, out_reg.new_a,
                            out_reg.index_c, out_reg.index_b, out_reg.index_a};
    assign m_axis_tuser  = out_reg.table_full;

    `MVW_ASSERT(a_load_free, cmd.load_out |-> out_free, "result overwritten before it was taken")

endmodule

[sv/mvw_ctrl.sv]
`include "mesh_vertex_weld_assert.svh"

module mvw_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_free,
    input  mvw_pkg::mvw_status_t st,
    output mvw_pkg::mvw_cmd_t   cmd
);
    import mvw_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_WR_A  = 3'd4;
    localparam logic [2:0] ST_WR_B  = 3'd5;
    localparam logic [2:0] ST_WR_C  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (st.scan_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!st.pipe_busy)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = st.full ? ST_DONE : ST_WR_A;
            end
            ST_WR_A:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_corner = CORNER_A;
                state_next    = ST_WR_B;
            end
            ST_WR_B:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_corner = CORNER_B;
                state_next    = ST_WR_C;
            end
            ST_WR_C:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_corner = CORNER_C;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `MVW_ASSERT(a_no_step_past_end, cmd.scan_step |-> !st.scan_end, "scan stepped past the table end")
    `MVW_ASSERT(a_check_after_drain, cmd.check |-> !st.pipe_busy, "table check with compares in flight")
    `MVW_ASSERT(a_start_only_idle, cmd.start |=> !in_ready, "item taken while busy")

endmodule

[sv/mvw_dp.sv]
`include "mesh_vertex_weld_assert.svh"

module mvw_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mvw_pkg::TOL_W-1:0]         cfg_wdata,
    input  logic [mvw_pkg::IN_DATA_W-1:0]     in_data,
    input  mvw_pkg::mvw_cmd_t                 cmd,
    output mvw_pkg::mvw_status_t              st,
    output mvw_pkg::mvw_result_t              result
);
    import mvw_pkg::*;

    // Vertex table, one entry per stored vertex.
    coord_t mem_x [MAX_VERTICES];
    coord_t mem_y [MAX_VERTICES];
    coord_t mem_z [MAX_VERTICES];

    logic [TOL_W-1:0] tol_reg;
    logic [SQ_W-1:0]  tolsq_reg;

    coord_t corner_reg [NUM_CORNERS][NUM_AXES];
    count_t count_reg;
    count_t scan_idx_reg;

    // Compare pipeline: read data, difference, magnitude, square, sum.
    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    addr_t             idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;
    coord_t            rd_reg [NUM_AXES];
    logic [DIFF_W-1:0] diff_reg [NUM_CORNERS][NUM_AXES];
    logic [DIFF_W-1:0] mag_reg [NUM_CORNERS][NUM_AXES];
    logic [SQ_W-1:0]   sq_reg [NUM_CORNERS][NUM_AXES];
    logic              far4_reg [NUM_CORNERS];
    logic              far5_reg [NUM_CORNERS];
    logic [SUM_W-1:0]  sum_reg [NUM_CORNERS];

    logic              found_reg [NUM_CORNERS];
    addr_t             idx_reg [NUM_CORNERS];
    logic              full_reg;

    logic              hit [NUM_CORNERS];
    logic [1:0]        need;
    logic              full;
    logic              wr_found;
    coord_t            wr_x, wr_y, wr_z;
    logic              mem_we;
    addr_t             wr_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        tolsq_reg <= SQ_W'(tol_reg) * SQ_W'(tol_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    corner_reg[c][a] <= in_data[(c * NUM_AXES + a) * COORD_W +: COORD_W];
                end
            end
        end
    end

    assign st.scan_end  = (scan_idx_reg == count_reg);
    assign st.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            v1_reg <= cmd.scan_step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            rd_reg[0] <= mem_x[scan_idx_reg[ADDR_W-1:0]];
            rd_reg[1] <= mem_y[scan_idx_reg[ADDR_W-1:0]];
            rd_reg[2] <= mem_z[scan_idx_reg[ADDR_W-1:0]];
        end
        if (mem_we)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
            mem_z[wr_addr] <= wr_z;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= scan_idx_reg[ADDR_W-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        idx5_reg <= idx4_reg;
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                diff_reg[c][a] <= {corner_reg[c][a][COORD_W-1], corner_reg[c][a]}
                                - {rd_reg[a][COORD_W-1], rd_reg[a]};
                mag_reg[c][a]  <= diff_reg[c][a][DIFF_W-1] ? (~diff_reg[c][a] + 1'b1)
                                                           : diff_reg[c][a];
                sq_reg[c][a]   <= SQ_W'(mag_reg[c][a][TOL_W-1:0])
                                * SQ_W'(mag_reg[c][a][TOL_W-1:0]);
            end
            // A magnitude at or above the tolerance rules the vertex out whatever its square.
            far4_reg[c] <= (mag_reg[c][0] >= DIFF_W'(tol_reg))
                         | (mag_reg[c][1] >= DIFF_W'(tol_reg))
                         | (mag_reg[c][2] >= DIFF_W'(tol_reg));
            far5_reg[c] <= far4_reg[c];
            sum_reg[c]  <= SUM_W'(sq_reg[c][0]) + SUM_W'(sq_reg[c][1]) + SUM_W'(sq_reg[c][2]);
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            hit[c] = v5_reg && !far5_reg[c] && (sum_reg[c] < SUM_W'(tolsq_reg));
        end
    end

    assign need = 2'(!found_reg[0]) + 2'(!found_reg[1]) + 2'(!found_reg[2]);
    assign full = ((CNT_W + 1)'(count_reg) + (CNT_W + 1)'(need)) > (CNT_W + 1)'(MAX_VERTICES);
    assign st.full = full;

    always_comb
    begin
        case (cmd.wr_corner)
            CORNER_B:
            begin
                wr_found = found_reg[1];
                wr_x     = corner_reg[1][0];
                wr_y     = corner_reg[1][1];
                wr_z     = corner_reg[1][2];
            end
            CORNER_C:
            begin
                wr_found = found_reg[2];
                wr_x     = corner_reg[2][0];
                wr_y     = corner_reg[2][1];
                wr_z     = corner_reg[2][2];
            end
            default:
            begin
                wr_found = found_reg[0];
                wr_x     = corner_reg[0][0];
                wr_y     = corner_reg[0][1];
                wr_z     = corner_reg[0][2];
            end
        endcase
    end

    assign mem_we  = cmd.wr_en && !wr_found;
    assign wr_addr = count_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            full_reg  <= 1'b0;
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                found_reg[c] <= 1'b0;
            end
        end
        else
        begin
            if (mem_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.check)
            begin
                full_reg <= full;
            end
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                if (cmd.start)
                begin
                    found_reg[c] <= 1'b0;
                end
                else if (hit[c])
                begin
                    found_reg[c] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            if (cmd.start)
            begin
                idx_reg[c] <= '0;
            end
            else if (hit[c] && !found_reg[c])
            begin
                idx_reg[c] <= idx5_reg;
            end
            else if (mem_we && (cmd.wr_corner == 2'(c)))
            begin
                idx_reg[c] <= wr_addr;
            end
        end
    end

    assign result.table_full = full_reg;
    assign result.new_a      = !full_reg && !found_reg[0];
    assign result.new_b      = !full_reg && !found_reg[1];
    assign result.new_c      = !full_reg && !found_reg[2];
    assign result.index_a    = full_reg ? '0 : to_out_idx(idx_reg[0]);
    assign result.index_b    = full_reg ? '0 : to_out_idx(idx_reg[1]);
    assign result.index_c    = full_reg ? '0 : to_out_idx(idx_reg[2]);

    `MVW_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_VERTICES), "vertex count beyond table")
    `MVW_ASSERT(a_count_step, mem_we |=> (count_reg == $past(count_reg) + 1'b1), "append lost")
    `MVW_ASSERT(a_start_empty, cmd.start |-> !st.pipe_busy, "new item with compares in flight")

endmodule

[test/tb_top.sv]
module tb_top;

    import mvw_pkg::*;

    localparam logic [TOL_W-1:0] TOL_MAX     = 31'h7FFF_FFFF;
    localparam logic [TOL_W-1:0] TOL_ONE     = 31'h0001_0000;
    localparam coord_t           POS_MAX     = 32'h7FFF_FFFF;
    localparam coord_t           NEG_MAX     = 32'h8000_0000;
    localparam longint           CYCLE_LIMIT = 40_000_000;

    typedef logic [NUM_CORNERS*NUM_AXES-1:0][COORD_W-1:0] triangle_t;

    typedef struct packed {
        logic                 full;
        logic                 pad;
        logic                 new_c;
        logic                 new_b;
        logic                 new_a;
        logic [OUT_IDX_W-1:0] index_c;
        logic [OUT_IDX_W-1:0] index_b;
        logic [OUT_IDX_W-1:0] index_a;
    } weld_result_t;

    typedef struct {
        bit           set_tol;
        logic [30:0]  tol;
        triangle_t    corners;
        bit           typed;
        weld_result_t want;
    } weld_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [TOL_W-1:0]      cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    coord_t                vtx_x [MAX_VERTICES];
    coord_t                vtx_y [MAX_VERTICES];
    coord_t                vtx_z [MAX_VERTICES];
    int unsigned           vtx_count = 0;
    logic [TOL_W-1:0]      weld_tol = '0;

    weld_result_t          weld_expected [$];
    weld_row_t             plan [$];
    int unsigned           errors = 0;
    int unsigned           n_triangles = 0;
    int unsigned           n_welded = 0;
    longint                cycles = 0;
    bit                    quiet = 1'b0;

    mesh_vertex_weld u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit corner_close(input triangle_t t, input int c, input int unsigned i);
        longint          d [3];
        longint unsigned lim;
        longint unsigned sum;
        int              k;
        lim  = longint'(weld_tol);
        d[0] = longint'($signed(t[3*c]))     - longint'($signed(vtx_x[i]));
        d[1] = longint'($signed(t[3*c + 1])) - longint'($signed(vtx_y[i]));
        d[2] = longint'($signed(t[3*c + 2])) - longint'($signed(vtx_z[i]));
        sum  = 0;
        for (k = 0; k < 3; k++)
        begin
            if (d[k] < 0)
                d[k] = -d[k];
            if (longint'(d[k]) >= longint'(lim))
                return 1'b0;
            sum += longint'(d[k]) * longint'(d[k]);
        end
        return sum < lim * lim;
    endfunction

    function automatic weld_result_t weld_triangle(input triangle_t t);
        weld_result_t r;
        int unsigned  hit [3];
        bit           found [3];
        int unsigned  need;
        int unsigned  n;
        int unsigned  i;
        int           c;
        r    = '0;
        need = 0;
        n    = vtx_count;
        n_triangles++;
        for (c = 0; c < 3; c++)
        begin
            found[c] = 1'b0;
            hit[c]   = 0;
            if (weld_tol != 0)
            begin
                for (i = 0; i < n; i++)
                begin
                    if (corner_close(t, c, i))
                    begin
                        found[c] = 1'b1;
                        hit[c]   = i;
                        break;
                    end
                end
            end
            if (!found[c])
                need++;
        end
        if (n + need > MAX_VERTICES)
        begin
            r.full = 1'b1;
            return r;
        end
        for (c = 0; c < 3; c++)
        begin
            if (!found[c])
            begin
                vtx_x[n] = t[3*c];
                vtx_y[n] = t[3*c + 1];
                vtx_z[n] = t[3*c + 2];
                hit[c]   = n;
                n++;
            end
            else
                n_welded++;
        end
        vtx_count = n;
        r.index_a = hit[0][OUT_IDX_W-1:0];
        r.index_b = hit[1][OUT_IDX_W-1:0];
        r.index_c = hit[2][OUT_IDX_W-1:0];
        r.new_a   = !found[0];
        r.new_b   = !found[1];
        r.new_c   = !found[2];
        return r;
    endfunction

    function automatic triangle_t corners_of(input coord_t ax, input coord_t ay, input coord_t az,
                                             input coord_t bx, input coord_t by_coord,
                                             input coord_t bz, input coord_t cx,
                                             input coord_t cy, input coord_t cz);
        return {cz, cy, cx, bz, by_coord, bx, az, ay, ax};
    endfunction

    function automatic weld_result_t result_of(input int ia, input int ib, input int ic,
                                               input bit na, input bit nb, input bit nc);
        weld_result_t r;
        r         = '0;
        r.index_a = ia[OUT_IDX_W-1:0];
        r.index_b = ib[OUT_IDX_W-1:0];
        r.index_c = ic[OUT_IDX_W-1:0];
        r.new_a   = na;
        r.new_b   = nb;
        r.new_c   = nc;
        return r;
    endfunction

    task automatic add_row(input bit set_tol, input logic [30:0] tol, input triangle_t corners,
                           input bit typed, input weld_result_t want);
        weld_row_t row;
        row.set_tol = set_tol;
        row.tol     = tol;
        row.corners = corners;
        row.typed   = typed;
        row.want    = want;
        plan.insert(plan.size(), row);
    endtask

    function automatic int unsigned draw_wait();
        if (quiet)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic coord_t shifted(input coord_t base, input longint off);
        return coord_t'(longint'($signed(base)) + off);
    endfunction

    // A corner near a stored vertex: inside the tolerance, exactly on it, or fresh.
    function automatic triangle_t random_corners();
        triangle_t   t;
        int unsigned mode;
        int unsigned pick;
        int unsigned span;
        bit          noise;
        int          c;
        int          k;
        noise = ($urandom_range(0, 9) < 3) || (vtx_count == 0);
        span  = weld_tol / 2;
        for (c = 0; c < 3; c++)
        begin
            mode = $urandom_range(0, 9);
            pick = $urandom_range(0, vtx_count - 1);
            for (k = 0; k < 3; k++)
                t[3*c + k] = coord_t'($urandom);
            if (!noise && mode < 6)
            begin
                t[3*c]     = shifted(vtx_x[pick], longint'($urandom_range(0, 2*span)) - span);
                t[3*c + 1] = shifted(vtx_y[pick], longint'($urandom_range(0, 2*span)) - span);
                t[3*c + 2] = shifted(vtx_z[pick], longint'($urandom_range(0, 2*span)) - span);
            end
            else if (!noise && mode == 6)
            begin
                t[3*c]     = shifted(vtx_x[pick], longint'(weld_tol));
                t[3*c + 1] = vtx_y[pick];
                t[3*c + 2] = vtx_z[pick];
            end
        end
        return t;
    endfunction

    task automatic send_triangle(input triangle_t t, input bit typed, input weld_result_t want);
        int unsigned  gap;
        weld_result_t r;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = weld_triangle(t);
        weld_expected.insert(weld_expected.size(), typed ? want : r);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (weld_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        weld_tol = v;
    endtask

    task automatic check_field(input string name, input logic [OUT_IDX_W-1:0] want,
                               input logic [OUT_IDX_W-1:0] seen);
        if (seen !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run stopped by the cycle limit with %0d items outstanding.",
                     weld_expected.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        weld_result_t got;
        weld_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata};
            if (weld_expected.size() == 0)
            begin
                errors++;
                $display("%0t: result expected none, got %h", $time, got);
            end
            else
            begin
                want = weld_expected.pop_front();
                check_field("index_a", want.index_a, got.index_a);
                check_field("index_b", want.index_b, got.index_b);
                check_field("index_c", want.index_c, got.index_c);
                check_field("new_a", OUT_IDX_W'(want.new_a), OUT_IDX_W'(got.new_a));
                check_field("new_b", OUT_IDX_W'(want.new_b), OUT_IDX_W'(got.new_b));
                check_field("new_c", OUT_IDX_W'(want.new_c), OUT_IDX_W'(got.new_c));
                check_field("pad", OUT_IDX_W'(want.pad), OUT_IDX_W'(got.pad));
                check_field("table_full", OUT_IDX_W'(want.full), OUT_IDX_W'(got.full));
            end
        end
    end

    initial
    begin
        int unsigned stall;
        forever
        begin
            stall = draw_wait();
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    initial
    begin
        weld_result_t none;
        int           p;
        int           j;
        logic [30:0]  tol_list [5];

        none        = '0;
        tol_list[0] = TOL_ONE;
        tol_list[1] = TOL_MAX;
        tol_list[2] = 31'h400;
        tol_list[3] = 31'h0030_0000;
        tol_list[4] = 31'd0;

        add_row(1'b0, 31'd0, corners_of(0, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b1, result_of(0, 1, 2, 1, 1, 1));
        add_row(1'b0, 31'd0, corners_of(0, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b1, result_of(3, 4, 5, 1, 1, 1));
        add_row(1'b0, 31'd0, corners_of(POS_MAX, POS_MAX, POS_MAX,
                                        NEG_MAX, NEG_MAX, NEG_MAX,
                                        POS_MAX, NEG_MAX, 32'hFFFF_FFFF),
                1'b1, result_of(6, 7, 8, 1, 1, 1));
        add_row(1'b1, 31'd1, corners_of(0, 0, 0, POS_MAX, POS_MAX, POS_MAX, 1, 0, 0),
                1'b1, result_of(0, 6, 9, 0, 0, 1));
        add_row(1'b0, 31'd0, corners_of(NEG_MAX, NEG_MAX, NEG_MAX, 1, 0, 0, 1, 0, 0),
                1'b1, result_of(7, 9, 9, 0, 0, 0));
        add_row(1'b1, TOL_ONE, corners_of(32'h1_0000, 0, 0, 32'hC000, 32'hC000, 0,
                                          32'h8000, 32'h8000, 32'h8000),
                1'b0, none);
        add_row(1'b1, TOL_MAX, corners_of(POS_MAX, POS_MAX, POS_MAX,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          POS_MAX, 0, 0),
                1'b0, none);
        add_row(1'b0, 31'd0, corners_of(NEG_MAX, NEG_MAX, NEG_MAX,
                                        32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                                        NEG_MAX, POS_MAX, 0),
                1'b0, none);
        add_row(1'b1, 31'd0, corners_of(32'h1234_5678, 32'hEDCB_A987, 1,
                                        32'h1234_5678, 32'hEDCB_A987, 1,
                                        32'hFFFF_0000, 32'h0000_FFFF, 32'h5555_AAAA),
                1'b0, none);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < plan.size(); p++)
        begin
            if (plan[p].set_tol)
            begin
                drain();
                write_tolerance(plan[p].tol);
            end
            send_triangle(plan[p].corners, plan[p].typed, plan[p].want);
        end

        for (j = 0; j < 5; j++)
        begin
            drain();
            write_tolerance(tol_list[j]);
            quiet = (j == 3);
            for (p = 0; p < 28; p++)
            begin
                if ($urandom_range(0, 19) == 0)
                    drain();
                send_triangle(random_corners(), 1'b0, none);
            end
        end

        quiet = 1'b0;
        drain();
        repeat (64) @(posedge clk);
        $display("Ran %0d triangles through the directed rows and five random tolerances,",
                 n_triangles);
        $display("with %0d corners welded and %0d vertices in the table at the end.",
                 n_welded, vtx_count);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
